// ===== rtl/core/hcfm_pkg.sv =====
// ---------------------------------------------------------------------------
// hcfm_pkg
// Shared types and constants of the head candidate filter and merge block.
// ---------------------------------------------------------------------------
package hcfm_pkg;

    // default geometry
    localparam int MAX_HEADS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 10;

    // fixed field widths
    localparam int RAD_W   = 12;   // Q8.4 radius
    localparam int DEPTH_W = 14;
    localparam int RATIO_W = 16;   // Q8.8 bound
    localparam int EXP_W   = 10;   // Q6.4 expected radius, max 1007
    localparam int PROD_W  = 60;   // polynomial terms stay below 2^60
    localparam int MUL_A_W = 48;   // operand held against depth

    // radius must exceed this to pass, Q8.4 (5 pixels)
    localparam logic [RAD_W-1:0] MIN_RADIUS = 12'd80;

    // 5.32 * polynomial coefficients, scaled by 2^44
    localparam logic [PROD_W-1:0]  K0 = 60'd17724155582500000;
    localparam logic [MUL_A_W-1:0] K1 = 48'd8554446039000;
    localparam logic [MUL_A_W-1:0] K2 = 48'd1725339572;
    localparam logic [MUL_A_W-1:0] K3 = 48'd129510;
    localparam int FRAC_SHIFT = 44;

    // register map (word index)
    localparam logic [1:0] REG_RATIO_MIN    = 2'd0;
    localparam logic [1:0] REG_RATIO_MAX    = 2'd1;
    localparam logic [1:0] REG_DEPTH_MARGIN = 2'd2;

    // input op codes
    localparam logic OP_CAND  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // top level control
    typedef enum logic [1:0] {
        S_IDLE,
        S_POLY,
        S_CHECK,
        S_TABLE
    } t_state;

    // polynomial sequencer steps
    typedef enum logic [3:0] {
        P_IDLE,
        P_K3D,
        P_K3D2,
        P_K3D3,
        P_K2D,
        P_K2D2,
        P_K1D,
        P_NEG,
        P_OUT
    } t_pstep;

    // head table control
    typedef enum logic [1:0] {
        T_IDLE,
        T_WALK,
        T_FLUSH
    } t_tstate;

    // command into the head table
    typedef struct packed {
        logic merge;
        logic flush;
    } t_tbl_cmd;

endpackage

// ===== rtl/core/hcfm_poly.sv =====
// ---------------------------------------------------------------------------
// hcfm_poly
// Expected head radius from centre depth: cubic evaluated on one shared
// 48x14 multiplier, one product per cycle, result in Q6.4.
// ---------------------------------------------------------------------------
module hcfm_poly
    import hcfm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DEPTH_W-1:0] i_depth,
    output logic               o_done,
    output logic [EXP_W-1:0]   o_exp
);

    t_pstep              r_step, n_step;
    logic [DEPTH_W-1:0]  r_d;
    logic [PROD_W-1:0]   r_p, r_pos, r_neg;
    logic [EXP_W-1:0]    r_e;
    logic                r_done;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_A_W+DEPTH_W-1:0] mul_full;
    logic [PROD_W-1:0]   prod, diff;

    // next step
    always_comb begin
        n_step = r_step;
        unique case (r_step)
            P_IDLE: if (i_start) n_step = P_K3D;
            P_K3D:  n_step = P_K3D2;
            P_K3D2: n_step = P_K3D3;
            P_K3D3: n_step = P_K2D;
            P_K2D:  n_step = P_K2D2;
            P_K2D2: n_step = P_K1D;
            P_K1D:  n_step = P_NEG;
            P_NEG:  n_step = P_OUT;
            P_OUT:  n_step = P_IDLE;
            default: n_step = P_IDLE;
        endcase
    end

    // multiplier operand
    always_comb begin
        unique case (r_step)
            P_K3D:   mul_a = K3;
            P_K2D:   mul_a = K2;
            P_K1D:   mul_a = K1;
            default: mul_a = r_p[MUL_A_W-1:0];
        endcase
    end

    assign mul_full = mul_a * r_d;
    assign prod     = mul_full[PROD_W-1:0];
    assign diff     = r_pos - r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= P_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= (r_step == P_OUT);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_step == P_IDLE && i_start) r_d <= i_depth;
        case (r_step)
            P_K3D, P_K3D2, P_K2D, P_K2D2: r_p <= prod;
            P_K3D3: r_neg <= prod;
            P_K1D: begin
                r_pos <= K0 + r_p;
                r_p   <= prod;
            end
            P_NEG: r_neg <= r_neg + r_p;
            P_OUT: r_e <= (r_pos > r_neg) ? diff[FRAC_SHIFT+EXP_W-1:FRAC_SHIFT] : '0;
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_exp  = r_e;

endmodule

// ===== rtl/core/hcfm_table.sv =====
// ---------------------------------------------------------------------------
// hcfm_table
// Head table in a synchronous memory: overlap walk with pipelined reads,
// replace or append, and the end-of-frame readout that clears the table.
// ---------------------------------------------------------------------------
module hcfm_table
    import hcfm_pkg::*;
#(
    parameter int MAX_HEADS   = MAX_HEADS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tbl_cmd               i_cmd,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  logic [RAD_W-1:0]       i_r,
    output logic                   o_done,
    output logic                   o_strobe,
    output logic [COORD_WIDTH-1:0] o_x,
    output logic [COORD_WIDTH-1:0] o_y,
    output logic [RAD_W-1:0]       o_r,
    output logic                   o_valid,
    output logic                   o_last,
    output logic                   o_dropped
);

    localparam int AW   = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
    localparam int CW   = $clog2(MAX_HEADS + 1);
    localparam int EW   = 2 * COORD_WIDTH + RAD_W;
    localparam int D2W  = 2 * COORD_WIDTH + 3 + 8;
    localparam int S2W  = 2 * (RAD_W + 1);
    localparam int CMPW = (D2W > S2W) ? D2W : S2W;
    localparam logic [CW-1:0] FULL = CW'(MAX_HEADS);

    logic [EW-1:0] mem [MAX_HEADS];

    t_tstate                r_st, n_st;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_ovf, n_ovf;
    logic [CW-1:0]          r_issue, n_issue;
    logic [CW-1:0]          r_cidx, n_cidx;
    logic                   r_pend, n_pend;
    logic [EW-1:0]          r_rdata;
    logic [COORD_WIDTH-1:0] r_cx, r_cy;
    logic [RAD_W-1:0]       r_cr;

    logic                   r_strobe, n_strobe;
    logic                   r_done, n_done;
    logic [COORD_WIDTH-1:0] r_ox, n_ox, r_oy, n_oy;
    logic [RAD_W-1:0]       r_or, n_or;
    logic                   r_ov, n_ov, r_ol, n_ol, r_od, n_od;

    logic                   w_en;
    logic [AW-1:0]          w_addr;
    logic [EW-1:0]          w_data;
    logic [AW-1:0]          rd_addr;

    // fields of the entry just read
    logic [COORD_WIDTH-1:0] e_x, e_y;
    logic [RAD_W-1:0]       e_r;
    logic [COORD_WIDTH-1:0] adx, ady;
    logic [2*COORD_WIDTH+1:0] dx2, dy2;
    logic [RAD_W:0]         sr;
    logic [S2W-1:0]         sr2;
    logic [CMPW-1:0]        d2_cmp, sr_cmp;
    logic                   hit, at_end;
    logic [CW-1:0]          last_idx;

    assign e_x = r_rdata[EW-1 -: COORD_WIDTH];
    assign e_y = r_rdata[RAD_W +: COORD_WIDTH];
    assign e_r = r_rdata[RAD_W-1:0];

    // circle overlap against the entry read last cycle
    always_comb begin
        adx    = (r_cx > e_x) ? (r_cx - e_x) : (e_x - r_cx);
        ady    = (r_cy > e_y) ? (r_cy - e_y) : (e_y - r_cy);
        dx2    = (2*COORD_WIDTH+2)'(adx) * (2*COORD_WIDTH+2)'(adx);
        dy2    = (2*COORD_WIDTH+2)'(ady) * (2*COORD_WIDTH+2)'(ady);
        sr     = {1'b0, r_cr} + {1'b0, e_r};
        sr2    = S2W'(sr) * S2W'(sr);
        d2_cmp = CMPW'({({1'b0, dx2} + {1'b0, dy2}), 8'd0});
        sr_cmp = CMPW'(sr2);
        hit    = d2_cmp < sr_cmp;
    end

    assign last_idx = r_count - CW'(1);
    assign at_end   = (r_cidx == last_idx);
    assign rd_addr  = r_issue[AW-1:0];

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            T_IDLE: begin
                if (i_cmd.flush && r_count != '0)      n_st = T_FLUSH;
                else if (i_cmd.merge && r_count != '0) n_st = T_WALK;
            end
            T_WALK:  if (r_pend && (hit || at_end)) n_st = T_IDLE;
            T_FLUSH: if (r_pend && at_end) n_st = T_IDLE;
            default: n_st = T_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_issue  = r_issue;
        n_cidx   = r_cidx;
        n_pend   = 1'b0;
        n_strobe = 1'b0;
        n_done   = 1'b0;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_or     = r_or;
        n_ov     = r_ov;
        n_ol     = r_ol;
        n_od     = r_od;
        w_en     = 1'b0;
        w_addr   = r_count[AW-1:0];
        w_data   = {r_cx, r_cy, r_cr};
        unique case (r_st)
            T_IDLE: begin
                n_issue = '0;
                if (i_cmd.merge && r_count == '0) begin
                    // empty table: append straight away
                    w_en    = 1'b1;
                    w_addr  = '0;
                    w_data  = {i_x, i_y, i_r};
                    n_count = CW'(1);
                    n_done  = 1'b1;
                end else if (i_cmd.flush && r_count == '0) begin
                    // empty flush: one beat without a head
                    n_strobe = 1'b1;
                    n_ox     = '0;
                    n_oy     = '0;
                    n_or     = '0;
                    n_ov     = 1'b0;
                    n_ol     = 1'b1;
                    n_od     = r_ovf;
                    n_ovf    = 1'b0;
                    n_done   = 1'b1;
                end
            end
            T_WALK: begin
                n_issue = r_issue + CW'(1);
                n_cidx  = r_issue;
                n_pend  = 1'b1;
                if (r_pend && hit) begin
                    n_pend = 1'b0;
                    n_done = 1'b1;
                    if (r_cr > e_r) begin
                        w_en   = 1'b1;
                        w_addr = r_cidx[AW-1:0];
                    end
                end else if (r_pend && at_end) begin
                    n_pend = 1'b0;
                    n_done = 1'b1;
                    if (r_count < FULL) begin
                        w_en    = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            T_FLUSH: begin
                n_issue = r_issue + CW'(1);
                n_cidx  = r_issue;
                n_pend  = (r_issue < r_count);
                if (r_pend) begin
                    n_strobe = 1'b1;
                    n_ox     = e_x;
                    n_oy     = e_y;
                    n_or     = e_r;
                    n_ov     = 1'b1;
                    n_ol     = at_end;
                    n_od     = r_ovf;
                    if (at_end) begin
                        n_pend  = 1'b0;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_done  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= T_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
            r_done   <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_issue <= n_issue;
        r_cidx  <= n_cidx;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_or    <= n_or;
        r_ov    <= n_ov;
        r_ol    <= n_ol;
        r_od    <= n_od;
        if (r_st == T_IDLE && i_cmd.merge) begin
            r_cx <= i_x;
            r_cy <= i_y;
            r_cr <= i_r;
        end
    end

    // head memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_en) mem[w_addr] <= w_data;
        r_rdata <= mem[rd_addr];
    end

    assign o_done    = r_done;
    assign o_strobe  = r_strobe;
    assign o_x       = r_ox;
    assign o_y       = r_oy;
    assign o_r       = r_or;
    assign o_valid   = r_ov;
    assign o_last    = r_ol;
    assign o_dropped = r_od;

    // table never holds more heads than it has entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL) else $error("head count above table depth");

    // result beats come only from a flush
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_strobe |-> (r_st == T_FLUSH || (r_st == T_IDLE && i_cmd.flush)))
        else $error("result beat outside flush");

    // the final beat of a flush leaves the table empty
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_ol) |-> (r_count == '0 && !r_ovf))
        else $error("table not cleared after last beat");

    // memory is never written during readout
    a_no_write_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == T_FLUSH) |-> !w_en) else $error("write during flush");

endmodule

// ===== rtl/core/head_candidate_filter_merge.sv =====
// ---------------------------------------------------------------------------
// head_candidate_filter_merge
// Head candidate acceptance test and merge into a per-frame head table.
// ---------------------------------------------------------------------------
// One item at a time: busy is high from the accepted start until the item is
// finished. A candidate gets its expected radius on the shared multiplier,
// then the acceptance test, and returns to idle when rejected; when it passes
// it is appended to an empty table straight away, or else merged by a table
// walk that reads one memory entry per cycle against the n stored heads.
// A flush of n heads puts out n beats on consecutive cycles, each on the
// result ports for one cycle with o_strobe high; the receiver cannot stall,
// so it must take a beat whenever o_strobe is high.
// An empty flush gives one beat with o_head_valid low and o_last high.
// ---------------------------------------------------------------------------
module head_candidate_filter_merge
    import hcfm_pkg::*;
#(
    parameter int MAX_HEADS   = MAX_HEADS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command
    input  logic                start,
    output logic                busy,
    input  logic                i_op,
    input  logic [9:0]          i_cand_x,
    input  logic [9:0]          i_cand_y,
    input  logic [RAD_W-1:0]    i_cand_radius,
    input  logic [DEPTH_W-1:0]  i_depth_centre,
    input  logic [DEPTH_W-1:0]  i_depth_left,
    input  logic [DEPTH_W-1:0]  i_depth_right,
    input  logic [DEPTH_W-1:0]  i_depth_up,
    // results
    output logic                o_strobe,
    output logic [9:0]          o_head_x,
    output logic [9:0]          o_head_y,
    output logic [RAD_W-1:0]    o_head_radius,
    output logic                o_head_valid,
    output logic                o_last,
    output logic                o_dropped,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    t_state                 r_state, n_state;
    logic [RATIO_W-1:0]     r_ratio_min, r_ratio_max;
    logic [DEPTH_W-1:0]     r_margin;
    logic [COORD_WIDTH-1:0] r_x, r_y;
    logic [RAD_W-1:0]       r_r;
    logic [DEPTH_W-1:0]     r_dl, r_dr, r_du, r_dc;

    logic                   accept, cfg_wr;
    logic                   poly_start, poly_done;
    logic [EXP_W-1:0]       exp_r;
    t_tbl_cmd               tbl_cmd;
    logic                   tbl_done;
    logic [COORD_WIDTH-1:0] tbl_x, tbl_y;

    logic [RAD_W+7:0]       rad_scaled;
    logic [RATIO_W+EXP_W-1:0] lo_bound, hi_bound;
    logic [DEPTH_W:0]       near;
    logic                   pass;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_min <= RATIO_W'(128);
            r_ratio_max <= RATIO_W'(512);
            r_margin    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_RATIO_MIN:    r_ratio_min <= pwdata[RATIO_W-1:0];
                REG_RATIO_MAX:    r_ratio_max <= pwdata[RATIO_W-1:0];
                REG_DEPTH_MARGIN: r_margin    <= pwdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_RATIO_MIN:    prdata = 32'(r_ratio_min);
            REG_RATIO_MAX:    prdata = 32'(r_ratio_max);
            REG_DEPTH_MARGIN: prdata = 32'(r_margin);
            default:          prdata = '0;
        endcase
    end

    // acceptance test on the registered expected radius
    always_comb begin
        rad_scaled = {r_r, 8'd0};
        lo_bound   = r_ratio_min * exp_r;
        hi_bound   = r_ratio_max * exp_r;
        near       = {1'b0, r_dc} + {1'b0, r_margin};
        pass       = (r_r > MIN_RADIUS) && (exp_r != '0)
                  && (26'(rad_scaled) > lo_bound) && (26'(rad_scaled) < hi_bound)
                  && (near < {1'b0, r_dl}) && (near < {1'b0, r_dr})
                  && (near < {1'b0, r_du});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = (i_op == OP_FLUSH) ? S_TABLE : S_POLY;
            end
            S_POLY:  if (poly_done) n_state = S_CHECK;
            S_CHECK: n_state = pass ? S_TABLE : S_IDLE;
            S_TABLE: if (tbl_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        poly_start    = 1'b0;
        tbl_cmd.merge = 1'b0;
        tbl_cmd.flush = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                poly_start    = accept && (i_op == OP_CAND);
                tbl_cmd.flush = accept && (i_op == OP_FLUSH);
            end
            S_CHECK: tbl_cmd.merge = pass;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // candidate beat held for the test and merge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x  <= COORD_WIDTH'(i_cand_x);
            r_y  <= COORD_WIDTH'(i_cand_y);
            r_r  <= i_cand_radius;
            r_dc <= i_depth_centre;
            r_dl <= i_depth_left;
            r_dr <= i_depth_right;
            r_du <= i_depth_up;
        end
    end

    hcfm_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (poly_start),
        .i_depth (i_depth_centre),
        .o_done  (poly_done),
        .o_exp   (exp_r)
    );

    hcfm_table #(
        .MAX_HEADS   (MAX_HEADS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (tbl_cmd),
        .i_x       (r_x),
        .i_y       (r_y),
        .i_r       (r_r),
        .o_done    (tbl_done),
        .o_strobe  (o_strobe),
        .o_x       (tbl_x),
        .o_y       (tbl_y),
        .o_r       (o_head_radius),
        .o_valid   (o_head_valid),
        .o_last    (o_last),
        .o_dropped (o_dropped)
    );

    assign o_head_x = 10'(tbl_x);
    assign o_head_y = 10'(tbl_y);

endmodule
